/* hdl/contact_state_majority_filter_assert.svh */
// assertion macros for the contact state majority filter
`ifndef CONTACT_STATE_MAJORITY_FILTER_ASSERT_SVH
`define CONTACT_STATE_MAJORITY_FILTER_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define CSMF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequence that holds in the cycle after the antecedent
`define CSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/csmf_pkg.sv */
// shared types, constants and helpers for the contact state majority filter
package csmf_pkg;

    // window depth default and the largest depth the counters support
    localparam int WINDOW_DEF = 10;
    localparam int WINDOW_MAX = 32;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // contact state codes
    localparam logic [1:0] CONTACT_NONE   = 2'd0;
    localparam logic [1:0] CONTACT_OFF    = 2'd1;
    localparam logic [1:0] CONTACT_OBJECT = 2'd2;
    localparam logic [1:0] CONTACT_SKIN   = 2'd3;

    // field widths
    localparam int RATE_IN_W  = 12;
    localparam int OXY_IN_W   = 10;
    localparam int RATE_OUT_W = 9;
    localparam int OXY_OUT_W  = 7;

    // reciprocal of ten in 15 fractional bits, exact floor for 12-bit inputs
    localparam int          RECIP_SHIFT = 15;
    localparam logic [11:0] RECIP_TEN   = 12'd3277;

    // per-state occupancy of the window plus the vote taken on it
    typedef struct packed {
        logic [CNT_W-1:0] n_off;
        logic [CNT_W-1:0] n_object;
        logic [CNT_W-1:0] n_skin;
        logic [1:0]       winner;
    } csmf_vote_t;

    // divide a 12-bit value by ten with one multiply and a shift
    function automatic logic [RATE_OUT_W-1:0] div_ten(input logic [RATE_IN_W-1:0] x);
        logic [2*RATE_IN_W-1:0] prod;
        prod = {{RATE_IN_W{1'b0}}, x} * {{RATE_IN_W{1'b0}}, RECIP_TEN};
        return prod[RECIP_SHIFT +: RATE_OUT_W];
    endfunction

endpackage

/* hdl/csmf_cell.sv */
// one stage of the contact state shift line
module csmf_cell
    import csmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic [1:0] state_in,
    output logic [1:0] state_out
);

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // take the neighbor's state on a shift
    assign state_next = shift_en ? state_in : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONTACT_NONE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state_out = state_reg;

endmodule

/* hdl/csmf_window.sv */
// window of recent contact states with running per-state counts and the vote
module csmf_window
    import csmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic [1:0] state_new,
    output csmf_vote_t vote_next
);

    logic [1:0] tap [WINDOW+1];

    logic [CNT_W-1:0] n_off_reg,    n_off_next;
    logic [CNT_W-1:0] n_object_reg, n_object_next;
    logic [CNT_W-1:0] n_skin_reg,   n_skin_next;
    logic [1:0]       state_old;

    assign tap[0]    = state_new;
    assign state_old = tap[WINDOW];

    // row of cells, the oldest state drops out at the far end
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        csmf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .state_in  (tap[i]),
            .state_out (tap[i+1])
        );
    end

    // count the incoming state, uncount the one leaving the window
    function automatic logic [CNT_W-1:0] cnt_upd(input logic [CNT_W-1:0] n,
                                                 input logic [1:0] code,
                                                 input logic [1:0] s_in,
                                                 input logic [1:0] s_out);
        logic [CNT_W-1:0] inc;
        logic [CNT_W-1:0] dec;
        inc = {{(CNT_W-1){1'b0}}, (s_in == code)};
        dec = {{(CNT_W-1){1'b0}}, (s_out == code)};
        return n + inc - dec;
    endfunction

    always_comb begin
        n_off_next    = n_off_reg;
        n_object_next = n_object_reg;
        n_skin_next   = n_skin_reg;
        if (shift_en) begin
            n_off_next    = cnt_upd(n_off_reg,    CONTACT_OFF,    state_new, state_old);
            n_object_next = cnt_upd(n_object_reg, CONTACT_OBJECT, state_new, state_old);
            n_skin_next   = cnt_upd(n_skin_reg,   CONTACT_SKIN,   state_new, state_old);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_off_reg    <= '0;
            n_object_reg <= '0;
            n_skin_reg   <= '0;
        end else begin
            n_off_reg    <= n_off_next;
            n_object_reg <= n_object_next;
            n_skin_reg   <= n_skin_next;
        end
    end

    // majority on the updated counts, ties to skin then object
    always_comb begin
        vote_next.n_off    = n_off_next;
        vote_next.n_object = n_object_next;
        vote_next.n_skin   = n_skin_next;
        priority if (n_skin_next >= n_off_next && n_skin_next >= n_object_next) begin
            vote_next.winner = CONTACT_SKIN;
        end else if (n_object_next >= n_off_next && n_object_next >= n_skin_next) begin
            vote_next.winner = CONTACT_OBJECT;
        end else begin
            vote_next.winner = CONTACT_OFF;
        end
    end

endmodule

/* hdl/contact_state_majority_filter.sv */
// top level of the contact state majority filter
//
// Takes one sensor report per clock while s_tready is high and returns one result beat per report.
// Reports with a read error or no contact state are passed through with
// accepted low; accepted reports taken while measuring shift their contact
// state into a row of WINDOW cells, and running per-state counters give the
// majority vote in the same cycle, so the result is registered in the cycle
// after the input beat. An output register separates the two sides: a new
// report is taken whenever the result register is empty or being drained.
// Heart rate and SpO2 are divided by ten with one reciprocal multiply each.
`include "contact_state_majority_filter_assert.svh"

module contact_state_majority_filter
    import csmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // fields from bit 0: status_bad[0], contact_raw[2:1], rate_tenths[14:3],
    // oxygen_tenths[24:15], measuring[25], zero pad[31:26]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: accepted[0], contact_filtered[2:1], heart_rate[11:3],
    // oxygen_level[18:12], zero pad[23:19]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic                  status_bad;
    logic [1:0]            contact_raw;
    logic [RATE_IN_W-1:0]  rate_tenths;
    logic [OXY_IN_W-1:0]   oxygen_tenths;
    logic                  measuring;

    logic                  in_beat;
    logic                  take_item;
    logic                  shift_en;
    csmf_vote_t            vote_next;
    logic [CNT_W+1:0]      vote_sum;
    logic                  held_clear;

    logic                  m_valid_reg,  m_valid_next;
    logic                  accepted_reg, accepted_next;
    logic [1:0]            filt_reg,     filt_next;
    logic [RATE_OUT_W-1:0] rate_reg,     rate_next;
    logic [OXY_OUT_W-1:0]  oxy_reg,      oxy_next;
    logic [RATE_OUT_W-1:0] oxy_div;

    // unpack the input beat
    assign status_bad    = s_tdata[0];
    assign contact_raw   = s_tdata[2:1];
    assign rate_tenths   = s_tdata[14:3];
    assign oxygen_tenths = s_tdata[24:15];
    assign measuring     = s_tdata[25];

    // handshake and window update enable
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign take_item = !status_bad && (contact_raw != CONTACT_NONE);
    assign shift_en  = in_beat && take_item && measuring;

    csmf_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (shift_en),
        .state_new (contact_raw),
        .vote_next (vote_next)
    );

    assign oxy_div = div_ten({{(RATE_IN_W-OXY_IN_W){1'b0}}, oxygen_tenths});

    // held display values
    always_comb begin
        filt_next = filt_reg;
        rate_next = rate_reg;
        oxy_next  = oxy_reg;
        if (shift_en) begin
            filt_next = vote_next.winner;
            if (vote_next.winner == CONTACT_SKIN) begin
                rate_next = div_ten(rate_tenths);
                if (oxygen_tenths != '0) begin
                    oxy_next = oxy_div[OXY_OUT_W-1:0];
                end
            end else begin
                rate_next = '0;
                oxy_next  = '0;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        accepted_next = accepted_reg;
        if (in_beat) begin
            m_valid_next  = 1'b1;
            accepted_next = take_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            accepted_reg <= 1'b0;
            filt_reg     <= CONTACT_NONE;
            rate_reg     <= '0;
            oxy_reg      <= '0;
        end else begin
            m_valid_reg  <= m_valid_next;
            accepted_reg <= accepted_next;
            filt_reg     <= filt_next;
            rate_reg     <= rate_next;
            oxy_reg      <= oxy_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, oxy_reg, rate_reg, filt_reg, accepted_reg};

    // window occupancy never exceeds its depth
    assign vote_sum = {2'b0, vote_next.n_off} + {2'b0, vote_next.n_object}
                    + {2'b0, vote_next.n_skin};

    // both held values at zero
    assign held_clear = (rate_reg == '0) && (oxy_reg == '0);

    `CSMF_ASSERT_ALWAYS(a_occupancy, vote_sum <= (CNT_W+2)'(WINDOW), "window count overflow")
    `CSMF_ASSERT_NEXT(a_filt_set, shift_en, filt_reg != CONTACT_NONE, "vote left state empty")
    `CSMF_ASSERT_ALWAYS(a_off_skin_zero, filt_reg == CONTACT_SKIN || held_clear, "not cleared")

endmodule
